[rtl/dmsp_pkg.sv]
// ----------------------------------------------------------------------------
// dmsp_pkg
// Shared types and constants of the display mode string parser.
// ----------------------------------------------------------------------------
package dmsp_pkg;

    // Default accumulator width; values saturate at 2^VALUE_BITS - 1.
    localparam int VALUE_BITS_DEF = 16;

    // Width of each reported value field.
    localparam int OUT_BITS = 17;

    // Number of held values (width, height, depth, rate).
    localparam int NUM_VALUES = 4;

    // Character codes used by the grammar.
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_UPX   = 8'h58;
    localparam logic [7:0] CH_LOWX  = 8'h78;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [3:0] DECIMAL_BASE = 4'd10;

    // Indexes of the value fields.
    localparam int IDX_WIDTH  = 0;
    localparam int IDX_HEIGHT = 1;
    localparam int IDX_DEPTH  = 2;
    localparam int IDX_RATE   = 3;

    typedef enum logic [8:0] {
        PH_BEFORE_W = 9'b000000001,
        PH_IN_W     = 9'b000000010,
        PH_BEFORE_H = 9'b000000100,
        PH_IN_H     = 9'b000001000,
        PH_BEFORE_D = 9'b000010000,
        PH_IN_D     = 9'b000100000,
        PH_BEFORE_R = 9'b001000000,
        PH_IN_R     = 9'b010000000,
        PH_DONE     = 9'b100000000
    } t_phase;

    typedef struct packed {
        logic [OUT_BITS-1:0] mode_rate;
        logic [OUT_BITS-1:0] mode_depth;
        logic [OUT_BITS-1:0] mode_height;
        logic [OUT_BITS-1:0] mode_width;
        logic                accepted;
    } t_result;

endpackage

[rtl/dmsp_acc.sv]
// ----------------------------------------------------------------------------
// dmsp_acc
// Saturating decimal accumulate step: acc * 10 + digit, clamped at the
// largest value that fits in VALUE_BITS.
// ----------------------------------------------------------------------------
module dmsp_acc #(
    parameter int VALUE_BITS = dmsp_pkg::VALUE_BITS_DEF
) (
    input  logic [VALUE_BITS-1:0] i_acc,
    input  logic [3:0]            i_digit,
    output logic [VALUE_BITS-1:0] o_acc
);

    localparam int SUM_BITS = VALUE_BITS + 4;

    logic [SUM_BITS-1:0] sum;

    // Times ten as two shifted copies; the result always fits in four extra bits.
    assign sum = {1'b0, i_acc, 3'b000} + {3'b000, i_acc, 1'b0}
               + {{VALUE_BITS{1'b0}}, i_digit};

    assign o_acc = (sum[SUM_BITS-1:VALUE_BITS] != 4'd0) ? {VALUE_BITS{1'b1}}
                                                        : sum[VALUE_BITS-1:0];

endmodule

[rtl/dmsp_parser.sv]
// ----------------------------------------------------------------------------
// dmsp_parser
// Per-character grammar state, working values and committed values.
// Produces one result on the last character of each string.
// ----------------------------------------------------------------------------
module dmsp_parser #(
    parameter int VALUE_BITS = dmsp_pkg::VALUE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_char,
    input  logic              i_last,
    output logic              o_res_valid,
    output dmsp_pkg::t_result o_res
);

    localparam int NV = dmsp_pkg::NUM_VALUES;
    localparam int OB = dmsp_pkg::OUT_BITS;

    dmsp_pkg::t_phase      r_phase, n_phase;
    logic                  r_valid, n_valid;
    logic [NV-1:0]         r_set, n_set;
    logic [VALUE_BITS-1:0] r_val [NV];
    logic [VALUE_BITS-1:0] n_val [NV];
    logic [OB-1:0]         r_held [NV];
    logic [OB-1:0]         n_held [NV];

    logic                  is_digit;
    logic                  is_space;
    logic [3:0]            digit;
    logic [VALUE_BITS-1:0] digit_val;
    logic [VALUE_BITS-1:0] acc_in;
    logic [VALUE_BITS-1:0] acc_out;
    logic                  commit;

    // Unset values read as all ones, set values as their low bits.
    function automatic logic [OB-1:0] f_conv(input logic set,
                                             input logic [VALUE_BITS-1:0] v);
        logic [VALUE_BITS+OB-1:0] wide;
        wide = {{OB{1'b0}}, v};
        return set ? wide[OB-1:0] : {OB{1'b1}};
    endfunction

    assign is_digit  = (i_char >= dmsp_pkg::CH_ZERO) && (i_char <= dmsp_pkg::CH_NINE);
    assign is_space  = (i_char == dmsp_pkg::CH_SPACE)
                    || ((i_char >= dmsp_pkg::CH_TAB) && (i_char <= dmsp_pkg::CH_CR));
    assign digit     = is_digit ? 4'(i_char - dmsp_pkg::CH_ZERO) : 4'd0;
    assign digit_val = {{(VALUE_BITS-4){1'b0}}, digit};

    // Only one value is being extended at a time, so one accumulator serves all.
    always_comb begin
        unique case (r_phase)
            dmsp_pkg::PH_IN_H: acc_in = r_val[dmsp_pkg::IDX_HEIGHT];
            dmsp_pkg::PH_IN_D: acc_in = r_val[dmsp_pkg::IDX_DEPTH];
            dmsp_pkg::PH_IN_R: acc_in = r_val[dmsp_pkg::IDX_RATE];
            default:           acc_in = r_val[dmsp_pkg::IDX_WIDTH];
        endcase
    end

    dmsp_acc #(
        .VALUE_BITS (VALUE_BITS)
    ) u_acc (
        .i_acc   (acc_in),
        .i_digit (digit),
        .o_acc   (acc_out)
    );

    always_comb begin
        n_phase = r_phase;
        n_valid = r_valid;
        n_set   = r_set;
        n_val   = r_val;
        n_held  = r_held;
        commit  = 1'b0;

        if (i_valid) begin
            unique case (r_phase)
                dmsp_pkg::PH_BEFORE_W: begin
                    if (is_digit) begin
                        n_val[dmsp_pkg::IDX_WIDTH] = digit_val;
                        n_set[dmsp_pkg::IDX_WIDTH] = 1'b1;
                        n_phase = dmsp_pkg::PH_IN_W;
                    end else if (!is_space) begin
                        n_phase = dmsp_pkg::PH_DONE;
                    end
                end
                dmsp_pkg::PH_IN_W: begin
                    if (is_digit) begin
                        n_val[dmsp_pkg::IDX_WIDTH] = acc_out;
                    end else if (i_char == dmsp_pkg::CH_LOWX || i_char == dmsp_pkg::CH_UPX) begin
                        n_phase = dmsp_pkg::PH_BEFORE_H;
                    end else begin
                        n_phase = dmsp_pkg::PH_DONE;
                    end
                end
                dmsp_pkg::PH_BEFORE_H: begin
                    if (is_digit) begin
                        n_val[dmsp_pkg::IDX_HEIGHT] = digit_val;
                        n_set[dmsp_pkg::IDX_HEIGHT] = 1'b1;
                        n_phase = dmsp_pkg::PH_IN_H;
                        n_valid = 1'b1;
                    end else begin
                        n_phase = dmsp_pkg::PH_DONE;
                    end
                end
                dmsp_pkg::PH_IN_H: begin
                    if (is_digit) begin
                        n_val[dmsp_pkg::IDX_HEIGHT] = acc_out;
                    end else if (i_char == dmsp_pkg::CH_AT) begin
                        n_phase = dmsp_pkg::PH_BEFORE_D;
                        n_valid = 1'b0;
                    end else if (i_char == dmsp_pkg::CH_COLON) begin
                        n_phase = dmsp_pkg::PH_BEFORE_R;
                        n_valid = 1'b0;
                    end else begin
                        n_phase = dmsp_pkg::PH_DONE;
                    end
                end
                dmsp_pkg::PH_BEFORE_D: begin
                    if (is_digit) begin
                        n_val[dmsp_pkg::IDX_DEPTH] = digit_val;
                        n_set[dmsp_pkg::IDX_DEPTH] = 1'b1;
                        n_phase = dmsp_pkg::PH_IN_D;
                        n_valid = 1'b1;
                    end else begin
                        n_phase = dmsp_pkg::PH_DONE;
                    end
                end
                dmsp_pkg::PH_IN_D: begin
                    if (is_digit) begin
                        n_val[dmsp_pkg::IDX_DEPTH] = acc_out;
                    end else if (i_char == dmsp_pkg::CH_COLON) begin
                        n_phase = dmsp_pkg::PH_BEFORE_R;
                        n_valid = 1'b0;
                    end else begin
                        n_phase = dmsp_pkg::PH_DONE;
                    end
                end
                dmsp_pkg::PH_BEFORE_R: begin
                    if (is_digit) begin
                        n_val[dmsp_pkg::IDX_RATE] = digit_val;
                        n_set[dmsp_pkg::IDX_RATE] = 1'b1;
                        n_phase = dmsp_pkg::PH_IN_R;
                        n_valid = 1'b1;
                    end else begin
                        n_phase = dmsp_pkg::PH_DONE;
                    end
                end
                dmsp_pkg::PH_IN_R: begin
                    if (is_digit) begin
                        n_val[dmsp_pkg::IDX_RATE] = acc_out;
                    end else begin
                        n_phase = dmsp_pkg::PH_DONE;
                    end
                end
                default: begin
                    n_phase = dmsp_pkg::PH_DONE;
                end
            endcase

            // The last character commits on the updated validity and then
            // rearms the parser for the next string.
            if (i_last) begin
                commit = n_valid;
                if (n_valid) begin
                    for (int k = 0; k < NV; k++) begin
                        n_held[k] = f_conv(n_set[k], n_val[k]);
                    end
                end
                n_phase = dmsp_pkg::PH_BEFORE_W;
                n_valid = 1'b0;
                n_set   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dmsp_pkg::PH_BEFORE_W;
            r_valid <= 1'b0;
            r_set   <= '0;
            for (int k = 0; k < NV; k++) begin
                r_held[k] <= {OB{1'b1}};
            end
        end else begin
            r_phase <= n_phase;
            r_valid <= n_valid;
            r_set   <= n_set;
            r_held  <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_res_valid       = i_valid && i_last;
    assign o_res.accepted    = commit;
    assign o_res.mode_width  = n_held[dmsp_pkg::IDX_WIDTH];
    assign o_res.mode_height = n_held[dmsp_pkg::IDX_HEIGHT];
    assign o_res.mode_depth  = n_held[dmsp_pkg::IDX_DEPTH];
    assign o_res.mode_rate   = n_held[dmsp_pkg::IDX_RATE];

endmodule

[rtl/dmsp_out_buf.sv]
// ----------------------------------------------------------------------------
// dmsp_out_buf
// Two-entry result buffer: an output register and a skid register, so the
// input side keeps moving while a result waits to be taken.
// ----------------------------------------------------------------------------
module dmsp_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  dmsp_pkg::t_result i_res,
    output logic              o_ready,
    output logic              o_valid,
    input  logic              i_take,
    output dmsp_pkg::t_result o_res
);

    logic              r_out_v, n_out_v;
    logic              r_skid_v, n_skid_v;
    dmsp_pkg::t_result r_out, n_out;
    dmsp_pkg::t_result r_skid, n_skid;

    // Space for a new result is guaranteed while the skid entry is empty.
    assign o_ready = !r_skid_v;
    assign o_valid = r_out_v;
    assign o_res   = r_out;

    always_comb begin
        n_out_v  = r_out_v;
        n_out    = r_out;
        n_skid_v = r_skid_v;
        n_skid   = r_skid;

        if (r_out_v && i_take) begin
            if (r_skid_v) begin
                n_out    = r_skid;
                n_skid_v = 1'b0;
            end else begin
                n_out_v = 1'b0;
            end
        end

        if (i_res_valid) begin
            if (!n_out_v) begin
                n_out   = i_res;
                n_out_v = 1'b1;
            end else begin
                n_skid   = i_res;
                n_skid_v = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

endmodule

[rtl/display_mode_string_parser_core.sv]
// ----------------------------------------------------------------------------
// display_mode_string_parser_core
// Parses mode strings such as 1920x1080@32:60 one character per transaction.
// ----------------------------------------------------------------------------
// The block takes one character per cycle on the slave stream, with tlast on
// the final character, and returns one result per string on the master
// stream. Each character updates the grammar state through a single shared
// multiply-by-ten accumulator, so a character is taken every cycle. Each
// result is registered in the output register, or in the skid register
// while that is full; this two-entry buffer keeps the input flowing while
// a result waits, and the slave side stalls only while two results wait.
// Unset values and values never committed read as all ones (minus one).
module display_mode_string_parser_core #(
    parameter int VALUE_BITS = dmsp_pkg::VALUE_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // char_code
    input  logic        i_s_tlast,   // is_last
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // accepted, mode_width, mode_height, mode_depth, mode_rate, zero pad
    output logic [71:0] o_m_tdata
);

    logic              s_accept;
    logic              res_valid;
    dmsp_pkg::t_result res;
    dmsp_pkg::t_result out_res;

    assign s_accept = i_s_tvalid && o_s_tready;

    dmsp_parser #(
        .VALUE_BITS (VALUE_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_accept),
        .i_char      (i_s_tdata),
        .i_last      (i_s_tlast),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    dmsp_out_buf u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_ready     (o_s_tready),
        .o_valid     (o_m_tvalid),
        .i_take      (i_m_tready),
        .o_res       (out_res)
    );

    assign o_m_tdata = {3'b000, out_res.mode_rate, out_res.mode_depth,
                        out_res.mode_height, out_res.mode_width, out_res.accepted};

endmodule

[test/mode_check_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mode_check_pkg
// Expected-result tracking for the display mode string parser testbench.
// ----------------------------------------------------------------------------
// The checker follows the grammar one character at a time with its own copy
// of the parser state. It queues the held values that each final character
// should report, and compares every result leaving the block against the
// oldest queued entry.
package mode_check_pkg;

    import dmsp_pkg::*;

    class mode_string_checker;

        int unsigned value_bits;
        longint      value_max;

        t_phase      phase;
        int          work_vals[NUM_VALUES];
        bit          valid_so_far;
        int          held_vals[NUM_VALUES];

        t_result     committed_modes_q[$];
        int          errors;

        function new(int unsigned vbits);
            value_bits = vbits;
            value_max  = (longint'(1) << vbits) - 1;
            errors     = 0;
            restart();
            foreach (held_vals[i]) held_vals[i] = -1;
        endfunction

        // Back to the state at the start of a string; held values stay.
        function void restart();
            phase        = PH_BEFORE_W;
            valid_so_far = 1'b0;
            foreach (work_vals[i]) work_vals[i] = -1;
        endfunction

        function int times_ten_plus(int acc, int digit);
            longint v;
            v = longint'(acc) * DECIMAL_BASE + digit;
            if (v > value_max) v = value_max;
            return int'(v);
        endfunction

        // Starts a value: it becomes valid as soon as its first digit arrives
        // (width is the exception, validity waits for the height).
        function void open_value(int idx, int digit, t_phase next_phase);
            work_vals[idx] = digit;
            phase          = next_phase;
            if (idx != IDX_WIDTH) valid_so_far = 1'b1;
        endfunction

        function void take_char(logic [7:0] c, logic last);
            bit      dig;
            bit      space;
            int      d;
            t_result r;

            dig   = (c >= CH_ZERO) && (c <= CH_NINE);
            d     = dig ? int'(c - CH_ZERO) : 0;
            space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));

            case (phase)
                PH_BEFORE_W: begin
                    if (dig) open_value(IDX_WIDTH, d, PH_IN_W);
                    else if (!space) phase = PH_DONE;
                end
                PH_IN_W: begin
                    if (dig) work_vals[IDX_WIDTH] = times_ten_plus(work_vals[IDX_WIDTH], d);
                    else if ((c == CH_LOWX) || (c == CH_UPX)) phase = PH_BEFORE_H;
                    else phase = PH_DONE;
                end
                PH_BEFORE_H: begin
                    if (dig) open_value(IDX_HEIGHT, d, PH_IN_H);
                    else phase = PH_DONE;
                end
                PH_IN_H: begin
                    if (dig) begin
                        work_vals[IDX_HEIGHT] = times_ten_plus(work_vals[IDX_HEIGHT], d);
                    end else if (c == CH_AT) begin
                        phase        = PH_BEFORE_D;
                        valid_so_far = 1'b0;
                    end else if (c == CH_COLON) begin
                        phase        = PH_BEFORE_R;
                        valid_so_far = 1'b0;
                    end else begin
                        phase = PH_DONE;
                    end
                end
                PH_BEFORE_D: begin
                    if (dig) open_value(IDX_DEPTH, d, PH_IN_D);
                    else phase = PH_DONE;
                end
                PH_IN_D: begin
                    if (dig) begin
                        work_vals[IDX_DEPTH] = times_ten_plus(work_vals[IDX_DEPTH], d);
                    end else if (c == CH_COLON) begin
                        phase        = PH_BEFORE_R;
                        valid_so_far = 1'b0;
                    end else begin
                        phase = PH_DONE;
                    end
                end
                PH_BEFORE_R: begin
                    if (dig) open_value(IDX_RATE, d, PH_IN_R);
                    else phase = PH_DONE;
                end
                PH_IN_R: begin
                    if (dig) work_vals[IDX_RATE] = times_ten_plus(work_vals[IDX_RATE], d);
                    else phase = PH_DONE;
                end
                default: phase = PH_DONE;
            endcase

            if (last) begin
                if (valid_so_far) held_vals = work_vals;
                r.accepted    = valid_so_far;
                r.mode_width  = OUT_BITS'(held_vals[IDX_WIDTH]);
                r.mode_height = OUT_BITS'(held_vals[IDX_HEIGHT]);
                r.mode_depth  = OUT_BITS'(held_vals[IDX_DEPTH]);
                r.mode_rate   = OUT_BITS'(held_vals[IDX_RATE]);
                committed_modes_q = {committed_modes_q, r};
                restart();
            end
        endfunction

        function void compare_field(string name, logic [OUT_BITS-1:0] exp_val,
                                    logic [OUT_BITS-1:0] act_val);
            if (act_val !== exp_val) begin
                $error("%s: expected %0h, got %0h", name, exp_val, act_val);
                errors++;
            end
        endfunction

        function void check_result(logic [71:0] data);
            t_result act;
            t_result exp_r;

            act = t_result'(data[$bits(t_result)-1:0]);
            if (committed_modes_q.size() == 0) begin
                $error("result with nothing expected: %h", data);
                errors++;
                return;
            end
            exp_r = committed_modes_q.pop_front();
            compare_field("accepted", OUT_BITS'(exp_r.accepted), OUT_BITS'(act.accepted));
            compare_field("mode_width", exp_r.mode_width, act.mode_width);
            compare_field("mode_height", exp_r.mode_height, act.mode_height);
            compare_field("mode_depth", exp_r.mode_depth, act.mode_depth);
            compare_field("mode_rate", exp_r.mode_rate, act.mode_rate);
        endfunction

        function int pending();
            return committed_modes_q.size();
        endfunction

    endclass

endpackage

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stream-level test of display_mode_string_parser_core.
// ----------------------------------------------------------------------------
// Mode strings go in one character per transaction with tlast on the final
// character. A short list of hand-picked strings comes first, then random
// strings, most of them well formed with random digits and some of them
// broken or pure noise. Both stream sides idle at random, and the result
// side holds off once for a long stretch so that the input stalls.
module tb;

    import dmsp_pkg::*;
    import mode_check_pkg::*;

    localparam int VALUE_BITS   = VALUE_BITS_DEF;
    localparam int RANDOM_CHARS = 1300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int LONG_HOLD    = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata;
    logic        i_s_tlast;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [71:0] o_m_tdata;

    mode_string_checker sb = new(VALUE_BITS);

    logic [7:0] str_q[$];
    int         sent_chars   = 0;
    int         cycle_count  = 0;
    int         hold_request = 0;
    bit         sender_burst = 1'b0;

    display_mode_string_parser_core #(
        .VALUE_BITS (VALUE_BITS)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
    end

    // Result side: random ready pattern, plus one long hold-off on request.
    initial begin
        int hold_served;
        int r;

        hold_served = 0;
        i_m_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_request != hold_served) begin
                hold_served = hold_request;
                i_m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    i_m_tready <= 1'b1;
                    repeat ($urandom_range(1, 30)) @(posedge i_clk);
                end else if (r < 88) begin
                    i_m_tready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge i_clk);
                end else begin
                    i_m_tready <= 1'b0;
                    repeat ($urandom_range(5, 25)) @(posedge i_clk);
                end
            end
        end
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (sender_burst || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    function automatic logic [7:0] pick_space();
        if ($urandom_range(0, 2) == 0) return CH_SPACE;
        return CH_TAB + 8'($urandom_range(0, 4));
    endfunction

    // Appends one character to the string being built.
    task automatic add_char(logic [7:0] c);
        str_q = {str_q, c};
    endtask

    task automatic add_text(string s);
        for (int i = 0; i < s.len(); i++) add_char(s[i]);
    endtask

    task automatic add_number();
        int ndig;
        // Mostly short values; a few long enough to saturate.
        ndig = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
        repeat (ndig) add_char(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // Sends the queued string, tlast on its final character, then empties it.
    task automatic send_string();
        int gap;
        for (int i = 0; i < str_q.size(); i++) begin
            gap = sender_gap();
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_s_tvalid <= 1'b1;
            i_s_tdata  <= str_q[i];
            i_s_tlast  <= (i == str_q.size() - 1);
            do @(posedge i_clk); while (!o_s_tready);
            sb.take_char(str_q[i], i == str_q.size() - 1);
            sent_chars++;
        end
        str_q.delete();
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic build_random_string();
        int kind;
        int pos;
        logic [7:0] junk;

        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 2)) add_char(pick_space());
        end
        add_number();
        add_char($urandom_range(0, 1) ? CH_LOWX : CH_UPX);
        add_number();
        if ($urandom_range(0, 1)) begin
            add_char(CH_AT);
            add_number();
        end
        if ($urandom_range(0, 1)) begin
            add_char(CH_COLON);
            add_number();
        end
        if ($urandom_range(0, 4) == 0) begin
            junk = 8'($urandom_range(0, 255));
            case ($urandom_range(0, 3))
                0: begin
                    pos = $urandom_range(1, str_q.size() - 1);
                    while (str_q.size() > pos) void'(str_q.pop_back());
                end
                1: str_q[$urandom_range(0, str_q.size() - 1)] = junk;
                2: add_char(junk);
                default: add_char($urandom_range(0, 1) ? CH_AT : CH_COLON);
            endcase
        end
    endtask

    initial begin
        int random_target;

        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tlast  <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Hand-picked strings: full form, leading whitespace with upper X,
        // saturation, a single character, a trailing separator, a parse stop
        // after a valid part, and a high character.
        sender_burst = 1'b1;
        add_text("1920x1080@32:60");
        send_string();
        sender_burst = 1'b0;
        add_text("\t0X9:7");
        send_string();
        add_text("999999x1");
        send_string();
        add_text("5");
        send_string();
        add_text("2x3@");
        send_string();
        add_text("4x5@6x");
        send_string();
        add_char(8'hFF);
        send_string();

        // The sender waits for every result before the random part.
        wait_drained();

        random_target = sent_chars + RANDOM_CHARS;
        while (sent_chars < random_target) begin
            if (hold_request == 0 && sent_chars > random_target - 900) hold_request = 1;
            if (sent_chars > random_target - 500 && sent_chars < random_target - 480) begin
                wait_drained();
            end
            sender_burst = ($urandom_range(0, 3) == 0);
            build_random_string();
            send_string();
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
